### design/spc_pkg.sv
// spc_pkg: shared widths, constants, arctangent table and request/result
// structs for the scan polar-to-Cartesian block.
// No dependencies.
`default_nettype none

package spc_pkg;

    // Field widths
    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 17;
    localparam int BIDX_W  = 12;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;

    // Datapath widths: x/y in Q32 millimetres, z in 2^-32 turn
    localparam int XY_W = 51;
    localparam int Z_W  = 34;
    localparam int R_W  = XY_W - 32;

    // Defaults for the top-level parameters
    localparam int MAX_BEAMS_DEF    = 4096;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC gain compensation, 0.60725293501 in Q32
    localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
    localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

    // Output saturation limit
    localparam logic signed [R_W-1:0] OUT_LIMIT = R_W'(65535);

    // Quarter and half turn in 16-bit binary angle units
    localparam logic signed [ANGLE_W:0] QUARTER_TURN = 17'sd16384;
    localparam logic signed [ANGLE_W:0] HALF_TURN    = 17'sd32768;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_MIN_RANGE   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_MAX_RANGE   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_START_ANGLE = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_ANGLE_STEP  = 2'd3;

    // Request into the CORDIC unit
    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] range;
        logic [ANGLE_W-1:0] angle;
    } spc_req_t;

    // Result out of the CORDIC unit
    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } spc_res_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:    v = 32'h2000_0000;
                5'd1:    v = 32'h12E4_051E;
                5'd2:    v = 32'h09FB_385B;
                5'd3:    v = 32'h0511_11D4;
                5'd4:    v = 32'h028B_0D43;
                5'd5:    v = 32'h0145_D7E1;
                5'd6:    v = 32'h00A2_F61E;
                5'd7:    v = 32'h0051_7C55;
                5'd8:    v = 32'h0028_BE53;
                5'd9:    v = 32'h0014_5F2F;
                5'd10:   v = 32'h000A_2F98;
                5'd11:   v = 32'h0005_17CC;
                5'd12:   v = 32'h0002_8BE6;
                5'd13:   v = 32'h0001_45F3;
                5'd14:   v = 32'h0000_A2FA;
                5'd15:   v = 32'h0000_517D;
                5'd16:   v = 32'h0000_28BE;
                5'd17:   v = 32'h0000_145F;
                5'd18:   v = 32'h0000_0A30;
                5'd19:   v = 32'h0000_0518;
                5'd20:   v = 32'h0000_028C;
                5'd21:   v = 32'h0000_0146;
                5'd22:   v = 32'h0000_00A3;
                5'd23:   v = 32'h0000_0051;
                default: v = 32'h0000_0000;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### design/spc_beam.sv
// spc_beam: beam index counter, range window check and beam angle product.
// Depends on spc_pkg.
`default_nettype none

module spc_beam
    import spc_pkg::*;
#(
    parameter int MAX_BEAMS = MAX_BEAMS_DEF,
    localparam int IDX_W = $clog2(MAX_BEAMS)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [RANGE_W-1:0] range_mm,
    input  wire logic               range_invalid,
    input  wire logic               scan_start,
    input  wire logic [CFG_W-1:0]   min_range,
    input  wire logic [CFG_W-1:0]   max_range,
    input  wire logic [CFG_W-1:0]   start_angle,
    input  wire logic [CFG_W-1:0]   angle_step,
    output logic                    keep,
    output logic [IDX_W-1:0]        idx,
    output logic [ANGLE_W-1:0]      angle
);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_BEAMS - 1);

    logic [IDX_W-1:0]       next_index_reg;
    logic [IDX_W-1:0]       next_index_next;
    logic [IDX_W-1:0]       idx_cur;
    logic [IDX_W-1:0]       idx_reg;
    logic [ANGLE_W-1:0]     prod_reg;
    logic [IDX_W+15:0]      prod_full;

    // Restart on scan start, otherwise take the running index
    assign idx_cur = scan_start ? '0 : next_index_reg;

    // Advance and saturate at the last beam
    always_comb
    begin
        next_index_next = next_index_reg;
        if (accept)
        begin
            next_index_next = (idx_cur < IDX_MAX) ? idx_cur + 1'b1 : idx_cur;
        end
    end

    // Drop invalid samples and those outside the range window
    assign keep = !range_invalid && (range_mm >= min_range) && (range_mm <= max_range);

    // Index times step, only the low 16 bits matter for a wrapping angle
    assign prod_full = (IDX_W + 16)'(idx_cur) * (IDX_W + 16)'(angle_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_index_reg <= '0;
        end
        else
        begin
            next_index_reg <= next_index_next;
        end
    end

    // Hold index and product of the accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= idx_cur;
            prod_reg <= prod_full[ANGLE_W-1:0];
        end
    end

    assign idx   = idx_reg;
    assign angle = start_angle + prod_reg;

endmodule

`default_nettype wire

### design/spc_cordic.sv
// spc_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle,
// with gain scaling, half-turn fold, rounding and saturation.
// Depends on spc_pkg.
`default_nettype none

module spc_cordic
    import spc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int CNT_W = $clog2(CORDIC_STEPS)
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire spc_req_t req,
    output spc_res_t      res
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_GAIN,
        C_ITER,
        C_ROUND,
        C_DONE
    } cstate_t;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    cstate_t                  state_reg;
    cstate_t                  state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [RANGE_W-1:0]       range_reg;
    logic                     flip_reg;
    logic signed [XY_W-1:0]   x_reg;
    logic signed [XY_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [OUT_W-1:0]  xo_reg;
    logic signed [OUT_W-1:0]  yo_reg;

    logic signed [ANGLE_W:0]  a_ext;
    logic signed [ANGLE_W:0]  a_fold;
    logic                     flip;
    logic signed [Z_W-1:0]    z_init;
    logic [47:0]              gain_prod;
    logic signed [XY_W-1:0]   xs;
    logic signed [XY_W-1:0]   ys;
    logic signed [Z_W-1:0]    atan_z;
    logic signed [XY_W-1:0]   x_neg;
    logic signed [XY_W-1:0]   y_neg;
    logic signed [OUT_W-1:0]  x_rnd;
    logic signed [OUT_W-1:0]  y_rnd;

    // Fold angles beyond a quarter turn by a half turn
    always_comb
    begin
        a_ext  = {req.angle[ANGLE_W-1], req.angle};
        flip   = (a_ext > QUARTER_TURN) || (a_ext < -QUARTER_TURN);
        a_fold = a_ext;
        if (flip)
        begin
            a_fold = (a_ext > 0) ? a_ext - HALF_TURN : a_ext + HALF_TURN;
        end
        z_init = {{(Z_W - ANGLE_W - 17){a_fold[ANGLE_W]}}, a_fold, 16'b0};
    end

    // Start vector: range times gain in Q32
    assign gain_prod = 48'(range_reg) * 48'(GAIN_Q32);

    // Shared micro-rotation datapath
    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_z = $signed({{(Z_W - 32){1'b0}}, atan_turn(5'(cnt_reg))});

    // Undo the fold, then round to millimetres and saturate
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        logic signed [R_W-1:0]  r;
        logic signed [OUT_W-1:0] o;
        begin
            t = v + $signed({{(XY_W - 32){1'b0}}, HALF_Q32});
            r = t[XY_W-1:32];
            if (r > OUT_LIMIT)
            begin
                o = OUT_W'(OUT_LIMIT);
            end
            else if (r < -OUT_LIMIT)
            begin
                o = OUT_W'(-OUT_LIMIT);
            end
            else
            begin
                o = r[OUT_W-1:0];
            end
            return o;
        end
    endfunction

    assign x_neg = flip_reg ? -x_reg : x_reg;
    assign y_neg = flip_reg ? -y_reg : y_reg;
    assign x_rnd = round_sat(x_neg);
    assign y_rnd = round_sat(y_neg);

    // Sequence: gain, iterations, round, then hold the result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  state_next = C_IDLE;
            C_GAIN:  state_next = C_ITER;
            C_ITER:  state_next = (cnt_reg == CNT_LAST) ? C_ROUND : C_ITER;
            C_ROUND: state_next = C_DONE;
            C_DONE:  state_next = C_DONE;
            default: state_next = C_IDLE;
        endcase
        if (req.start)
        begin
            state_next = C_GAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            range_reg <= req.range;
            flip_reg  <= flip;
            z_reg     <= z_init;
        end
        else
        begin
            unique case (state_reg)
                C_GAIN:
                begin
                    x_reg   <= $signed({{(XY_W - 48){1'b0}}, gain_prod});
                    y_reg   <= '0;
                    cnt_reg <= '0;
                end
                C_ITER:
                begin
                    if (!z_reg[Z_W-1])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_z;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_z;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                C_ROUND:
                begin
                    xo_reg <= x_rnd;
                    yo_reg <= y_rnd;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res.done = (state_reg == C_DONE);
    assign res.x    = xo_reg;
    assign res.y    = yo_reg;

endmodule

`default_nettype wire

### design/scan_polar_to_cartesian.sv
// scan_polar_to_cartesian: top level with configuration registers,
// request sequencer and output register. Depends on spc_pkg, spc_beam, spc_cordic.
//
//  Channel   Direction  Handshake                  Content
//  s_axis    in         tvalid/tready              range sample, invalid flag, scan start
//  m_axis    out        tvalid/tready              x, y, beam index
//  cfg       in         cfg_we (no wait)           min/max range, start angle, angle step
//
// A kept request raises the result valid after the launch, the gain product, the
// rotations, the rounding and the load of the output register. The next request is
// taken the cycle after the load; a dropped sample leaves the input ready. Input is
// not taken while a request is in the CORDIC unit.
// A result waits in the output register until taken; a new request may be
// taken meanwhile and stalls before its own result if the register is full.
// Reset is asynchronous and clears the beam index and all control state.
`default_nettype none

module scan_polar_to_cartesian
    import spc_pkg::*;
#(
    parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [15:0]        s_axis_tdata,   // [15:0] range_mm
    input  wire logic [1:0]         s_axis_tuser,   // [0] range_invalid, [1] scan_start
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [47:0]             m_axis_tdata,   // [16:0] x_mm, [33:17] y_mm,
                                                    // [45:34] beam_index, [47:46] zero
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_BEAMS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ANGLE,
        S_RUN
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CFG_W-1:0]         min_range_reg;
    logic [CFG_W-1:0]         max_range_reg;
    logic [CFG_W-1:0]         start_angle_reg;
    logic [CFG_W-1:0]         angle_step_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [OUT_W-1:0]  x_out_reg;
    logic signed [OUT_W-1:0]  y_out_reg;
    logic [BIDX_W-1:0]        idx_out_reg;
    logic [RANGE_W-1:0]       range_reg;

    logic                     in_accept;
    logic                     keep;
    logic [IDX_W-1:0]         idx;
    logic [ANGLE_W-1:0]       angle;
    logic                     out_free;
    logic                     out_load;
    spc_req_t                 req;
    spc_res_t                 res;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == S_RUN) && res.done && out_free;

    // Beam index and angle
    spc_beam #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_beam (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .range_mm      (s_axis_tdata[RANGE_W-1:0]),
        .range_invalid (s_axis_tuser[0]),
        .scan_start    (s_axis_tuser[1]),
        .min_range     (min_range_reg),
        .max_range     (max_range_reg),
        .start_angle   (start_angle_reg),
        .angle_step    (angle_step_reg),
        .keep          (keep),
        .idx           (idx),
        .angle         (angle)
    );

    // Launch the CORDIC once the angle is settled
    assign req.start = (state_reg == S_ANGLE);
    assign req.range = range_reg;
    assign req.angle = angle;

    spc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = (in_accept && keep) ? S_ANGLE : S_IDLE;
            S_ANGLE: state_next = S_RUN;
            S_RUN:   state_next = out_load ? S_IDLE : S_RUN;
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            min_range_reg   <= 16'd0;
            max_range_reg   <= 16'd65535;
            start_angle_reg <= 16'd0;
            angle_step_reg  <= 16'd182;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MIN_RANGE:   min_range_reg   <= cfg_data;
                    REG_MAX_RANGE:   max_range_reg   <= cfg_data;
                    REG_START_ANGLE: start_angle_reg <= cfg_data;
                    REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            range_reg <= s_axis_tdata[RANGE_W-1:0];
        end
        if (out_load)
        begin
            x_out_reg   <= res.x;
            y_out_reg   <= res.y;
            idx_out_reg <= BIDX_W'(idx);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, idx_out_reg, y_out_reg, x_out_reg};

`ifndef SYNTH
    // CORDIC is never done in the cycle right after a launch
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ANGLE) |=> (state_reg == S_RUN) && !res.done)
        else $error("cordic reports done right after launch");

    // A new result appears only from a finished CORDIC run
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_RUN) && $past(res.done))
        else $error("result loaded without a finished run");

    // Saturation keeps coordinates within +-65535
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (x_out_reg != 17'sh10000) && (y_out_reg != 17'sh10000))
        else $error("coordinate outside saturation limit");

    // Input is held off while a request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && keep) |=> !s_axis_tready)
        else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

### test/scan_polar_to_cartesian_test.sv
// Self-checking testbench for scan_polar_to_cartesian: drives range samples over the stream
// input, predicts each Cartesian point with its own fixed-point CORDIC and checks the output.
// Depends on spc_pkg and the scan_polar_to_cartesian RTL.
module scan_polar_to_cartesian_test
    import spc_pkg::*;
();

    localparam int SETTLE         = 2 * (CORDIC_STEPS_DEF + 5);
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int BEAM_LAST      = MAX_BEAMS_DEF - 1;

    // Arctangent of 2^-i, units of 2^-32 turn
    localparam longint ATAN_TBL [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [BIDX_W-1:0]       beam;
    } point_t;

    // Predicts Cartesian points from accepted samples and checks them in order
    class point_checker;
        logic [CFG_W-1:0] min_r;
        logic [CFG_W-1:0] max_r;
        logic [CFG_W-1:0] ang_base;
        logic [CFG_W-1:0] ang_step;
        int unsigned      beam_next;
        point_t           point_q[$];
        int               errors;

        function new();
            min_r     = 16'd0;
            max_r     = 16'hFFFF;
            ang_base  = 16'd0;
            ang_step  = 16'd182;
            beam_next = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_W-1:0] v);
            case (addr)
                REG_MIN_RANGE:   min_r = v;
                REG_MAX_RANGE:   max_r = v;
                REG_START_ANGLE: ang_base = v;
                REG_ANGLE_STEP:  ang_step = v;
                default: ;
            endcase
        endfunction

        // Round Q32 to nearest (ties up) and clip to the output limit
        function logic signed [OUT_W-1:0] round_clip(longint q);
            longint r;
            r = (q + 64'sh8000_0000) >>> 32;
            if (r > 65535)
                r = 65535;
            if (r < -65535)
                r = -65535;
            return r[OUT_W-1:0];
        endfunction

        // Rotation-mode CORDIC of (range*K, 0) by a 16-bit binary angle
        function point_t rotate(logic [RANGE_W-1:0] r, logic [ANGLE_W-1:0] ang);
            point_t p;
            int     a;
            bit     flip;
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            a = int'($signed(ang));
            flip = 1'b0;
            // fold the back half-plane into +-90 degrees, negate at the end
            if (a > 16384 || a < -16384)
            begin
                a = (a > 0) ? a - 32768 : a + 32768;
                flip = 1'b1;
            end
            z = longint'(a) * 64'sd65536;
            x = longint'({48'd0, r}) * 64'sd2608131496;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TBL[i];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TBL[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            p.x = round_clip(x);
            p.y = round_clip(y);
            p.beam = '0;
            return p;
        endfunction

        // Advance the beam index and queue the point this sample gives, if any
        function void note_sample(logic [RANGE_W-1:0] r, bit inv, bit st);
            int unsigned idx;
            logic [31:0] acc;
            point_t      p;
            idx = st ? 0 : beam_next;
            if (idx > BEAM_LAST)
                idx = BEAM_LAST;
            beam_next = (idx < BEAM_LAST) ? idx + 1 : idx;
            if (inv || r < min_r || r > max_r)
                return;
            acc = 32'(ang_base) + idx * 32'(ang_step);
            p = rotate(r, acc[ANGLE_W-1:0]);
            p.beam = idx[BIDX_W-1:0];
            point_q.insert(point_q.size(), p);
        endfunction

        task report(string field, int got, int want);
            errors++;
            $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        endtask

        task check_point(logic [47:0] d);
            point_t p;
            if (point_q.size() == 0)
            begin
                report("unexpected point x_mm", int'($signed(d[16:0])), 0);
                return;
            end
            p = point_q.pop_front();
            if (d[16:0] !== p.x)
                report("x_mm", int'($signed(d[16:0])), int'(p.x));
            if (d[33:17] !== p.y)
                report("y_mm", int'($signed(d[33:17])), int'(p.y));
            if (d[45:34] !== p.beam)
                report("beam_index", int'(d[45:34]), int'(p.beam));
            if (d[47:46] !== 2'b00)
                report("tdata padding", int'(d[47:46]), 0);
        endtask

        function int pending();
            return point_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [47:0]        m_axis_tdata;
    logic               cfg_we;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_data;

    point_checker points;
    bit           send_fast;
    bit           hold_req;
    int           idle_cycles;

    scan_polar_to_cartesian u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] range_mm
        .s_axis_tuser  (s_axis_tuser),   // [0] range_invalid, [1] scan_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [16:0] x_mm, [33:17] y_mm, [45:34] beam_index
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Offer one sample after a random gap and hold it until the request is taken
    task automatic send_sample(logic [15:0] r, bit inv, bit st);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        s_axis_tuser  <= {st, inv};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        points.note_sample(r, inv, st);
    endtask

    // Drop valid, wait for every expected point, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (points.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= v;
        points.write_reg(addr, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] lo, logic [15:0] hi, logic [15:0] base,
                              logic [15:0] step);
        write_reg(REG_MIN_RANGE, lo);
        write_reg(REG_MAX_RANGE, hi);
        write_reg(REG_START_ANGLE, base);
        write_reg(REG_ANGLE_STEP, step);
    endtask

    // Mostly in-window ranges, with full-range, edge and tiny values mixed in
    function automatic logic [15:0] pick_range(logic [15:0] lo, logic [15:0] hi);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && lo <= hi)
            return 16'($urandom_range(int'(hi), int'(lo)));
        if (sel < 8)
            return 16'($urandom);
        if (sel == 9)
            return 16'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return lo;
            3:       return hi;
            4:       return lo - 16'd1;
            default: return hi + 16'd1;
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'd182;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random settings, then scans of random length with random content
    task automatic run_random_phase(int n, bit with_hold);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] t;
        int          sent;
        int          scan_len;
        bit          inv;
        bit          st;
        drain();
        lo = 16'($urandom);
        hi = 16'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            1:
            begin
                if (lo > hi)
                begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
            end
            2: ;
            default:
            begin
                lo = 16'd0;
                hi = 16'($urandom_range(0, 300));
            end
        endcase
        set_config(lo, hi, pick_angle(), pick_angle());
        sent = 0;
        while (sent < n)
        begin
            scan_len = $urandom_range(1, 300);
            for (int k = 0; k < scan_len && sent < n; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_fast = !send_fast;
                if (with_hold && sent == 20)
                    hold_req = 1'b1;
                st  = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
                inv = ($urandom_range(0, 11) == 0);
                send_sample(pick_range(lo, hi), inv, st);
                sent++;
            end
        end
        send_fast = 1'b0;
    endtask

    // Receiver: random stalls, bursts without stalls, one long hold-off on request
    initial
    begin
        int gap;
        bit fast;
        m_axis_tready = 1'b0;
        fast = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                fast = !fast;
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = fast ? 0 : $urandom_range(0, 18);
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            points.check_point(m_axis_tdata);
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence
    initial
    begin
        points        = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        send_fast     = 1'b0;
        hold_req      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: range extremes, invalid flag, start mark with invalid
        send_sample(16'hFFFF, 1'b0, 1'b1);
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'd1000, 1'b1, 1'b0);
        send_sample(16'd1, 1'b0, 1'b0);
        send_sample(16'd40000, 1'b1, 1'b1);
        send_sample(16'd32768, 1'b0, 1'b0);

        // Quarter-turn steps: both +-90 degree edges and the half turn
        drain();
        set_config(16'd0, 16'hFFFF, 16'd0, 16'd16384);
        send_sample(16'hFFFF, 1'b0, 1'b1);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);

        // Extreme start angle and step
        drain();
        set_config(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_sample(16'd50000, 1'b0, 1'b1);
        send_sample(16'd50000, 1'b0, 1'b0);
        send_sample(16'd50000, 1'b0, 1'b0);
        drain();
        set_config(16'd0, 16'hFFFF, 16'd16385, 16'h8000);
        send_sample(16'd30000, 1'b0, 1'b1);
        send_sample(16'd30000, 1'b0, 1'b0);

        // Range window edges
        drain();
        set_config(16'd1000, 16'd2000, 16'h2000, 16'd1);
        send_sample(16'd999, 1'b0, 1'b1);
        send_sample(16'd1000, 1'b0, 1'b0);
        send_sample(16'd2000, 1'b0, 1'b0);
        send_sample(16'd2001, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);

        // Empty window: minimum above maximum
        drain();
        set_config(16'd5000, 16'd4000, 16'd0, 16'd182);
        send_sample(16'd4500, 1'b0, 1'b1);
        send_sample(16'd5000, 1'b0, 1'b0);
        send_sample(16'd4000, 1'b0, 1'b0);

        // Random phases
        for (int p = 0; p < RAND_PHASES; p++)
            run_random_phase(PHASE_ITEMS, p == 1);

        drain();
        if (points.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
